### sv/tpep_pkg.sv
// types and constants shared by the pattern event packer
// no dependencies
package tpep_pkg;

	localparam int NUM_SLOTS   = 5;
	localparam int SLOT_W      = 3;
	localparam int LEN_W       = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] FLAG_BASE = 8'h80;
	localparam logic [3:0] ALL_FOUR  = 4'hF;

	localparam logic [1:0] REG_STANDARD_MODE = 2'd0;

	typedef struct packed {
		logic [7:0] note_value;
		logic [7:0] instrument_value;
		logic [7:0] volume_value;
		logic [7:0] effect_code;
		logic [7:0] effect_param;
		logic [7:0] lane_type;
		logic [7:0] lane_data;
		logic       lane_valid;
		logic       effect_is_extension;
		logic       pattern_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             last_byte;
		logic [LEN_W-1:0] packed_length;
	} out_item_t;

	// one classified event: the bytes to send in order, how many, and a length clear
	typedef struct packed {
		logic [NUM_SLOTS-1:0][7:0] seq;
		logic [SLOT_W-1:0]         count;
		logic                      clear_len;
	} desc_t;

endpackage

### sv/tpep_front.sv
// front end: applies the effect rules and builds the ordered byte list of one event
// depends on tpep_pkg
module tpep_front
	import tpep_pkg::*;
(
	input  in_item_t item,
	input  logic     standard_mode,
	output desc_t    desc
);

	logic [NUM_SLOTS-1:0][7:0] b;
	logic [3:0]                bits;
	logic [SLOT_W-1:0]         j;

	always_comb begin
		b[0] = item.note_value;
		b[1] = item.instrument_value;
		b[2] = item.volume_value;
		b[3] = item.effect_code;
		b[4] = item.effect_param;
		// outside standard mode, an empty effect slot takes a valid tuning lane
		if (!standard_mode && item.effect_code == 8'd0 && item.effect_param == 8'd0
				&& item.lane_valid) begin
			b[3] = item.lane_type;
			b[4] = item.lane_data;
		end
		// extension effects are dropped in standard mode
		if (standard_mode && item.effect_is_extension) begin
			b[3] = 8'd0;
			b[4] = 8'd0;
		end
		for (int i = 0; i < 4; i++) begin
			bits[i] = (b[i] != 8'd0);
		end

		desc.seq       = '0;
		desc.clear_len = item.pattern_start;
		j              = '0;
		if (bits == ALL_FOUR) begin
			desc.seq   = b;
			desc.count = SLOT_W'(NUM_SLOTS);
		end else begin
			desc.seq[0] = FLAG_BASE | {3'b000, (b[4] != 8'd0), bits};
			j           = SLOT_W'(1);
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (b[i] != 8'd0) begin
					desc.seq[j] = b[i];
					j           = j + SLOT_W'(1);
				end
			end
			desc.count = j;
		end
	end

endmodule

### sv/tpep_fifo.sv
// short descriptor queue between the front and back ends
// depends on tpep_pkg
module tpep_fifo
	import tpep_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output desc_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t             entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### sv/tpep_back.sv
// back end: sends the queued bytes one per cycle while the receiver is ready and keeps the running length
// depends on tpep_pkg
module tpep_back
	import tpep_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  desc_t     head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [SLOT_W-1:0] idx_q;
	logic [LEN_W-1:0]  len_q;
	logic              out_valid_q;
	out_item_t         out_q;
	logic              load;
	logic              is_last;
	logic [LEN_W-1:0]  base_len;
	logic [LEN_W-1:0]  new_len;

	assign load     = head_valid && (!out_valid_q || out_ready);
	assign is_last  = (idx_q == head.count - SLOT_W'(1));
	assign pop      = load && is_last;
	assign base_len = (idx_q == '0 && head.clear_len) ? '0 : len_q;
	assign new_len  = base_len + LEN_W'(1);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				len_q       <= new_len;
				idx_q       <= is_last ? '0 : idx_q + SLOT_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte      <= head.seq[idx_q];
			out_q.last_byte     <= is_last;
			out_q.packed_length <= new_len;
		end
	end

	// mid-event position only while the event is still at the queue head
	a_idx_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> head_valid)
		else $error("byte index advanced with no event queued");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q < head.count)
		else $error("byte index beyond event length");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == '0)
		else $error("next event does not start at its first byte");

	a_len_steps: assert property (@(posedge clk) disable iff (!arst_n)
		load && !(idx_q == '0 && head.clear_len) |=> len_q == $past(len_q) + LEN_W'(1))
		else $error("running length did not advance by one byte");

endmodule

### sv/tracker_pattern_event_packer_top.sv
// top level of the pattern event packer: config register, front end, queue, back end
// depends on tpep_pkg, tpep_front, tpep_fifo, tpep_back
//
// usage
//  - in channel (in_valid/in_ready/in_data): one pattern event per item, five event
//    bytes, the tuning lane pair and the lane, extension and pattern start flags
//  - out channel (out_valid/out_ready/out_data): one packed byte per item, with
//    last_byte on the final byte of an event and the running packed length
//  - apb port: one register at byte address 0, bit 0 is standard_mode; write only
//    while the block is idle
//  - an event yields 1 to 5 bytes: five raw bytes when note, instrument, volume and
//    effect are all present, else a flag byte followed by the nonzero bytes
//  - the first byte of an event passes through the queue entry and then the back end
//    output register before it is valid on the out port
//  - throughput: one byte per cycle while an event is queued and the receiver is
//    ready; the byte serializer in the back end sets this rate
//  - in_ready depends only on the descriptor queue having room, so events keep
//    arriving while the back end is still sending earlier ones
//  - receiver stall: the output register holds its byte, the back end stops, the
//    queue fills and then in_ready drops
//  - reset clears standard_mode, the running length, the queue and the output valid
module tracker_pattern_event_packer_top
	import tpep_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// event input
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	// packed byte output
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic  standard_mode_q;
	desc_t front_desc;
	logic  queue_full;
	logic  head_valid;
	desc_t head;
	logic  pop;

	// config register, only one so the address just selects the read data
	assign pready = 1'b1;
	assign prdata = (paddr == REG_STANDARD_MODE) ? {31'd0, standard_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			standard_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			standard_mode_q <= pwdata[0];
		end
	end

	// front end classifies the event as it is accepted
	tpep_front u_front (
		.item          (in_data),
		.standard_mode (standard_mode_q),
		.desc          (front_desc)
	);

	assign in_ready = !queue_full;

	// decouples acceptance from byte output
	tpep_fifo #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid),
		.push_data  (front_desc),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back end sends one byte per cycle into the output register while the receiver is ready
	tpep_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
